>>> design/nrsp_pkg.sv
package nrsp_pkg;

	localparam int unsigned MAX_RECORDS = 8;
	localparam int unsigned REC_CNT_W = 4;

	// parse phases
	localparam logic [2:0] PH_FLAG = 3'd0;
	localparam logic [2:0] PH_TLEN = 3'd1;
	localparam logic [2:0] PH_PLEN = 3'd2;
	localparam logic [2:0] PH_ILEN = 3'd3;
	localparam logic [2:0] PH_TYPE = 3'd4;
	localparam logic [2:0] PH_ID   = 3'd5;
	localparam logic [2:0] PH_PAY  = 3'd6;

	// byte roles
	localparam logic [2:0] SEC_HEADER  = 3'd0;
	localparam logic [2:0] SEC_TYPE    = 3'd1;
	localparam logic [2:0] SEC_ID      = 3'd2;
	localparam logic [2:0] SEC_PAYLOAD = 3'd3;
	localparam logic [2:0] SEC_IGNORED = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_MANY = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;

	// first body section to try
	localparam logic [1:0] STG_TYPE = 2'd0;
	localparam logic [1:0] STG_ID   = 2'd1;
	localparam logic [1:0] STG_PAY  = 2'd2;
	localparam logic [1:0] STG_NONE = 2'd3;

	localparam logic [7:0] FLAG_ME  = 8'h40;
	localparam logic [7:0] FLAG_SR  = 8'h10;
	localparam logic [7:0] FLAG_IL  = 8'h08;
	localparam logic [7:0] TNF_MASK = 8'h07;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  section;
		logic [7:0]  content_byte;
		logic        record_done;
		logic [2:0]  record_index;
		logic [2:0]  record_tnf;
		logic [7:0]  type_length;
		logic [7:0]  id_length;
		logic [31:0] payload_length;
		logic        message_end;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] left;
		logic        done;
	} sec_step_t;

	// Skip empty sections starting at stg; done when nothing is left.
	function automatic sec_step_t enter_sec(input logic [1:0] stg, input logic [7:0] tlen,
			input logic idf, input logic [7:0] ilen, input logic [31:0] plen);
		sec_step_t r;
		r.phase = PH_FLAG;
		r.left  = '0;
		r.done  = 1'b1;
		if (stg <= STG_PAY && plen != '0) begin
			r.phase = PH_PAY;
			r.left  = plen;
			r.done  = 1'b0;
		end
		if (stg <= STG_ID && idf && ilen != '0) begin
			r.phase = PH_ID;
			r.left  = {24'd0, ilen};
			r.done  = 1'b0;
		end
		if (stg == STG_TYPE && tlen != '0) begin
			r.phase = PH_TYPE;
			r.left  = {24'd0, tlen};
			r.done  = 1'b0;
		end
		return r;
	endfunction

endpackage

>>> design/nrsp_if.sv
interface nrsp_in_if;
	logic                valid;
	logic                ready;
	nrsp_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface nrsp_out_if;
	logic                 valid;
	logic                 ready;
	nrsp_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> design/ndef_record_stream_parser.sv
// NDEF record stream parser.
// byte_ch carries one message byte per transfer, with last_byte set on the final
// byte of the buffer. result_ch returns exactly one item per input byte, in order:
// the byte's section tag, the byte itself, and on the byte that closes a record
// the record descriptor (index, TNF, type/id/payload lengths, message end).
// status flags too many records or a buffer that ended inside a record.
// A byte accepted on byte_ch passes through the input register and then the result
// register before it shows on result_ch. Throughput: one byte per cycle unless
// result_ch stalls; parser state loads together with the result register.
// Reset clears the parser to await a flag byte and empties both registers.
// After a byte with last_byte the parser returns to that same state.
// When result_ch stalls, the result register holds and the input register can
// still take one more byte; byte_ch.ready drops once both are full.
module ndef_record_stream_parser (
	input  logic               clk,
	input  logic               arst_n,
	nrsp_in_if.sink            byte_ch,
	nrsp_out_if.source         result_ch
);

	logic                 valid_s1;
	nrsp_pkg::in_item_t  item_s1;
	logic                 valid_s2;
	nrsp_pkg::out_item_t res_s2;
	logic                 adv_s2;
	logic                 load_s2;

	logic [2:0]  phase_q;
	logic        short_q;
	logic        idf_q;
	logic        end_q;
	logic [2:0]  tnf_q;
	logic [7:0]  tlen_q;
	logic [7:0]  ilen_q;
	logic [31:0] plen_q;
	logic [31:0] left_q;
	logic [1:0]  lcnt_q;
	logic [nrsp_pkg::REC_CNT_W-1:0] seen_q;
	logic        closed_q;

	logic [2:0]  phase_n;
	logic        short_n;
	logic        idf_n;
	logic        end_n;
	logic [2:0]  tnf_n;
	logic [7:0]  tlen_n;
	logic [7:0]  ilen_n;
	logic [31:0] plen_n;
	logic [31:0] left_n;
	logic [1:0]  lcnt_n;
	logic [nrsp_pkg::REC_CNT_W-1:0] seen_n;
	logic        closed_n;
	nrsp_pkg::out_item_t res_n;
	nrsp_pkg::sec_step_t es;
	logic        done;
	logic        ignored;
	logic [7:0]  d;

	assign adv_s2 = !valid_s2 || result_ch.ready;
	assign load_s2 = valid_s1 && adv_s2;
	assign byte_ch.ready = !valid_s1 || adv_s2;
	assign result_ch.valid = valid_s2;
	assign result_ch.payload = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			item_s1 <= byte_ch.payload;
		end
	end

	always_comb begin
		d        = item_s1.data_byte;
		phase_n  = phase_q;
		short_n  = short_q;
		idf_n    = idf_q;
		end_n    = end_q;
		tnf_n    = tnf_q;
		tlen_n   = tlen_q;
		ilen_n   = ilen_q;
		plen_n   = plen_q;
		left_n   = left_q;
		lcnt_n   = lcnt_q;
		seen_n   = seen_q;
		closed_n = closed_q;
		done     = 1'b0;
		ignored  = 1'b0;
		es       = '0;
		res_n    = '0;
		res_n.content_byte = d;
		res_n.section = nrsp_pkg::SEC_HEADER;
		res_n.status = nrsp_pkg::ST_OK;

		if (closed_q) begin
			ignored = 1'b1;
			res_n.section = nrsp_pkg::SEC_IGNORED;
		end else begin
			unique case (phase_q) inside
				nrsp_pkg::PH_FLAG: begin
					end_n   = (d & nrsp_pkg::FLAG_ME) != '0;
					short_n = (d & nrsp_pkg::FLAG_SR) != '0;
					idf_n   = (d & nrsp_pkg::FLAG_IL) != '0;
					tnf_n   = d[2:0] & nrsp_pkg::TNF_MASK[2:0];
					tlen_n  = '0;
					ilen_n  = '0;
					plen_n  = '0;
					lcnt_n  = '0;
					phase_n = nrsp_pkg::PH_TLEN;
				end
				nrsp_pkg::PH_TLEN: begin
					tlen_n  = d;
					plen_n  = '0;
					lcnt_n  = '0;
					phase_n = nrsp_pkg::PH_PLEN;
				end
				nrsp_pkg::PH_PLEN: begin
					plen_n = {plen_q[23:0], d};
					if (short_q || lcnt_q == 2'd3) begin
						lcnt_n = '0;
						if (idf_q) begin
							phase_n = nrsp_pkg::PH_ILEN;
						end else begin
							es      = nrsp_pkg::enter_sec(nrsp_pkg::STG_TYPE, tlen_q, idf_q,
								ilen_q, plen_n);
							phase_n = es.phase;
							left_n  = es.left;
							done    = es.done;
						end
					end else begin
						lcnt_n = lcnt_q + 2'd1;
					end
				end
				nrsp_pkg::PH_ILEN: begin
					ilen_n  = d;
					es      = nrsp_pkg::enter_sec(nrsp_pkg::STG_TYPE, tlen_q, idf_q, d, plen_q);
					phase_n = es.phase;
					left_n  = es.left;
					done    = es.done;
				end
				nrsp_pkg::PH_TYPE, nrsp_pkg::PH_ID, nrsp_pkg::PH_PAY: begin
					left_n = left_q - 32'd1;
					if (phase_q == nrsp_pkg::PH_TYPE) begin
						res_n.section = nrsp_pkg::SEC_TYPE;
						es = nrsp_pkg::enter_sec(nrsp_pkg::STG_ID, tlen_q, idf_q, ilen_q, plen_q);
					end else if (phase_q == nrsp_pkg::PH_ID) begin
						res_n.section = nrsp_pkg::SEC_ID;
						es = nrsp_pkg::enter_sec(nrsp_pkg::STG_PAY, tlen_q, idf_q, ilen_q, plen_q);
					end else begin
						res_n.section = nrsp_pkg::SEC_PAYLOAD;
						es = nrsp_pkg::enter_sec(nrsp_pkg::STG_NONE, tlen_q, idf_q, ilen_q, plen_q);
					end
					if (left_q == 32'd1) begin
						phase_n = es.phase;
						left_n  = es.left;
						done    = es.done;
					end
				end
				default: begin
					phase_n = nrsp_pkg::PH_FLAG;
				end
			endcase
		end

		if (done) begin
			if (seen_q < nrsp_pkg::REC_CNT_W'(nrsp_pkg::MAX_RECORDS)) begin
				res_n.record_done    = 1'b1;
				res_n.record_index   = seen_q[2:0];
				res_n.record_tnf     = tnf_q;
				res_n.type_length    = tlen_n;
				res_n.id_length      = idf_q ? ilen_n : 8'd0;
				res_n.payload_length = plen_n;
				res_n.message_end    = end_q;
				seen_n = seen_q + 1'b1;
				if (end_q) begin
					closed_n = 1'b1;
				end
			end else begin
				res_n.status = nrsp_pkg::ST_TOO_MANY;
				closed_n = 1'b1;
			end
		end else if (item_s1.last_byte && !ignored) begin
			res_n.status = nrsp_pkg::ST_TRUNC;
		end

		if (item_s1.last_byte) begin
			phase_n  = nrsp_pkg::PH_FLAG;
			short_n  = 1'b0;
			idf_n    = 1'b0;
			end_n    = 1'b0;
			tnf_n    = '0;
			tlen_n   = '0;
			ilen_n   = '0;
			plen_n   = '0;
			left_n   = '0;
			lcnt_n   = '0;
			seen_n   = '0;
			closed_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= nrsp_pkg::PH_FLAG;
			short_q  <= 1'b0;
			idf_q    <= 1'b0;
			end_q    <= 1'b0;
			tnf_q    <= '0;
			tlen_q   <= '0;
			ilen_q   <= '0;
			plen_q   <= '0;
			left_q   <= '0;
			lcnt_q   <= '0;
			seen_q   <= '0;
			closed_q <= 1'b0;
		end else if (load_s2) begin
			phase_q  <= phase_n;
			short_q  <= short_n;
			idf_q    <= idf_n;
			end_q    <= end_n;
			tnf_q    <= tnf_n;
			tlen_q   <= tlen_n;
			ilen_q   <= ilen_n;
			plen_q   <= plen_n;
			left_q   <= left_n;
			lcnt_q   <= lcnt_n;
			seen_q   <= seen_n;
			closed_q <= closed_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			res_s2 <= res_n;
		end
	end

`ifndef SYNTHESIS
	a_done_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.record_done |-> res_s2.status == nrsp_pkg::ST_OK)
		else $error("record completed with error status");

	a_ignored_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.section == nrsp_pkg::SEC_IGNORED |->
		!res_s2.record_done && res_s2.status == nrsp_pkg::ST_OK)
		else $error("ignored byte carries record or status");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 && item_s1.last_byte |=>
		phase_q == nrsp_pkg::PH_FLAG && seen_q == '0 && !closed_q)
		else $error("parser not reset after last byte");

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= nrsp_pkg::REC_CNT_W'(nrsp_pkg::MAX_RECORDS))
		else $error("record count beyond limit");

	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == nrsp_pkg::PH_TYPE || phase_q == nrsp_pkg::PH_ID ||
		phase_q == nrsp_pkg::PH_PAY) |-> left_q != '0)
		else $error("body section with no bytes left");
`endif

endmodule

>>> sim/tb_ndef_record_stream_parser.sv
`timescale 1ns / 100ps

module tb_ndef_record_stream_parser;

	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned TOTAL_BYTES  = 1650;
	localparam int unsigned DRAIN_CYCLES = 10;

	typedef struct {
		logic [2:0]  phase;
		logic        short_rec;
		logic        has_id;
		logic        msg_end;
		logic [2:0]  tnf;
		logic [7:0]  tlen;
		logic [7:0]  ilen;
		logic [31:0] plen;
		logic [31:0] remain;
		logic [1:0]  len_cnt;
		logic [3:0]  rec_count;
		logic        closed;
	} parser_state_t;

	logic clk;
	logic arst_n;

	nrsp_in_if  byte_ch ();
	nrsp_out_if result_ch ();

	ndef_record_stream_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	parser_state_t       parser_st;
	nrsp_pkg::out_item_t tagged_bytes_q[$];
	logic [7:0]          msg_bytes[$];
	int unsigned         mismatches = 0;
	int unsigned         sent_count = 0;
	bit                  src_gaps = 1'b1;
	bit                  snk_gaps = 1'b1;
	bit                  hold_req = 1'b0;

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void reset_parser();
		parser_st.phase     = nrsp_pkg::PH_FLAG;
		parser_st.short_rec = 1'b0;
		parser_st.has_id    = 1'b0;
		parser_st.msg_end   = 1'b0;
		parser_st.tnf       = '0;
		parser_st.tlen      = '0;
		parser_st.ilen      = '0;
		parser_st.plen      = '0;
		parser_st.remain    = '0;
		parser_st.len_cnt   = '0;
		parser_st.rec_count = '0;
		parser_st.closed    = 1'b0;
	endfunction

	// first non-empty body section from stg on; returns 1 when the record is complete
	function automatic logic open_body(logic [1:0] stg);
		if (stg == nrsp_pkg::STG_TYPE && parser_st.tlen != 8'd0) begin
			parser_st.phase  = nrsp_pkg::PH_TYPE;
			parser_st.remain = 32'(parser_st.tlen);
			return 1'b0;
		end
		if (stg <= nrsp_pkg::STG_ID && parser_st.has_id && parser_st.ilen != 8'd0) begin
			parser_st.phase  = nrsp_pkg::PH_ID;
			parser_st.remain = 32'(parser_st.ilen);
			return 1'b0;
		end
		if (stg <= nrsp_pkg::STG_PAY && parser_st.plen != 32'd0) begin
			parser_st.phase  = nrsp_pkg::PH_PAY;
			parser_st.remain = parser_st.plen;
			return 1'b0;
		end
		parser_st.phase  = nrsp_pkg::PH_FLAG;
		parser_st.remain = '0;
		return 1'b1;
	endfunction

	function automatic nrsp_pkg::out_item_t parse_byte(nrsp_pkg::in_item_t b);
		nrsp_pkg::out_item_t r;
		logic                done;
		logic                skip;
		r              = '0;
		done           = 1'b0;
		skip           = parser_st.closed;
		r.content_byte = b.data_byte;
		r.section      = skip ? nrsp_pkg::SEC_IGNORED : nrsp_pkg::SEC_HEADER;
		if (!skip) begin
			case (parser_st.phase)
				nrsp_pkg::PH_FLAG: begin
					parser_st.msg_end   = (b.data_byte & nrsp_pkg::FLAG_ME) != 8'd0;
					parser_st.short_rec = (b.data_byte & nrsp_pkg::FLAG_SR) != 8'd0;
					parser_st.has_id    = (b.data_byte & nrsp_pkg::FLAG_IL) != 8'd0;
					parser_st.tnf       = 3'(b.data_byte & nrsp_pkg::TNF_MASK);
					parser_st.tlen      = '0;
					parser_st.ilen      = '0;
					parser_st.plen      = '0;
					parser_st.len_cnt   = '0;
					parser_st.phase     = nrsp_pkg::PH_TLEN;
				end
				nrsp_pkg::PH_TLEN: begin
					parser_st.tlen    = b.data_byte;
					parser_st.plen    = '0;
					parser_st.len_cnt = '0;
					parser_st.phase   = nrsp_pkg::PH_PLEN;
				end
				nrsp_pkg::PH_PLEN: begin
					parser_st.plen = {parser_st.plen[23:0], b.data_byte};
					if (parser_st.short_rec || parser_st.len_cnt == 2'd3) begin
						parser_st.len_cnt = '0;
						if (parser_st.has_id)
							parser_st.phase = nrsp_pkg::PH_ILEN;
						else
							done = open_body(nrsp_pkg::STG_TYPE);
					end else begin
						parser_st.len_cnt = parser_st.len_cnt + 2'd1;
					end
				end
				nrsp_pkg::PH_ILEN: begin
					parser_st.ilen = b.data_byte;
					done = open_body(nrsp_pkg::STG_TYPE);
				end
				nrsp_pkg::PH_TYPE: begin
					r.section = nrsp_pkg::SEC_TYPE;
					parser_st.remain = parser_st.remain - 32'd1;
					if (parser_st.remain == 32'd0)
						done = open_body(nrsp_pkg::STG_ID);
				end
				nrsp_pkg::PH_ID: begin
					r.section = nrsp_pkg::SEC_ID;
					parser_st.remain = parser_st.remain - 32'd1;
					if (parser_st.remain == 32'd0)
						done = open_body(nrsp_pkg::STG_PAY);
				end
				nrsp_pkg::PH_PAY: begin
					r.section = nrsp_pkg::SEC_PAYLOAD;
					parser_st.remain = parser_st.remain - 32'd1;
					if (parser_st.remain == 32'd0)
						done = open_body(nrsp_pkg::STG_NONE);
				end
				default: begin
					parser_st.phase = nrsp_pkg::PH_FLAG;
				end
			endcase
		end
		if (done) begin
			if (parser_st.rec_count < nrsp_pkg::MAX_RECORDS) begin
				r.record_done    = 1'b1;
				r.record_index   = parser_st.rec_count[2:0];
				r.record_tnf     = parser_st.tnf;
				r.type_length    = parser_st.tlen;
				r.id_length      = parser_st.has_id ? parser_st.ilen : 8'd0;
				r.payload_length = parser_st.plen;
				r.message_end    = parser_st.msg_end;
				parser_st.rec_count = parser_st.rec_count + 4'd1;
				if (parser_st.msg_end)
					parser_st.closed = 1'b1;
			end else begin
				r.status = nrsp_pkg::ST_TOO_MANY;
				parser_st.closed = 1'b1;
			end
		end else if (b.last_byte && !skip) begin
			r.status = nrsp_pkg::ST_TRUNC;
		end
		if (b.last_byte)
			reset_parser();
		return r;
	endfunction

	// starts and ends at a falling edge; valid stays high for a back-to-back transfer
	task automatic send_byte(logic [7:0] data, logic last);
		int unsigned         gap;
		nrsp_pkg::in_item_t  item;
		nrsp_pkg::out_item_t exp;
		gap = src_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			byte_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item.data_byte  = data;
		item.last_byte  = last;
		byte_ch.payload = item;
		byte_ch.valid   = 1'b1;
		do @(posedge clk); while (!byte_ch.ready);
		exp = parse_byte(item);
		tagged_bytes_q.push_back(exp);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_message();
		int unsigned n;
		n = msg_bytes.size();
		for (int unsigned i = 0; i < n; i++)
			send_byte(msg_bytes[i], i == n - 1);
		if (n != 0)
			byte_ch.valid = 1'b0;
		msg_bytes.delete();
	endtask

	// MB and CF bits are don't-care to the parser, so they are random
	function automatic logic [7:0] flag_byte(logic me, logic sr, logic il, logic [2:0] tnf);
		return {1'($urandom), me, 1'($urandom), sr, il, tnf};
	endfunction

	function automatic void add_record(logic [7:0] flags, logic [7:0] tlen, logic [7:0] ilen,
			logic [31:0] plen, int unsigned pay_cap);
		logic il;
		il = (flags & nrsp_pkg::FLAG_IL) != 8'd0;
		msg_bytes.push_back(flags);
		msg_bytes.push_back(tlen);
		if ((flags & nrsp_pkg::FLAG_SR) != 8'd0) begin
			msg_bytes.push_back(plen[7:0]);
		end else begin
			msg_bytes.push_back(plen[31:24]);
			msg_bytes.push_back(plen[23:16]);
			msg_bytes.push_back(plen[15:8]);
			msg_bytes.push_back(plen[7:0]);
		end
		if (il)
			msg_bytes.push_back(ilen);
		repeat (tlen) msg_bytes.push_back(8'($urandom));
		if (il)
			repeat (ilen) msg_bytes.push_back(8'($urandom));
		for (int unsigned i = 0; i < plen && i < pay_cap; i++)
			msg_bytes.push_back(8'($urandom));
	endfunction

	function automatic logic [7:0] pick_len();
		return ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
	endfunction

	task automatic check_field(string name, logic [31:0] exp, logic [31:0] got);
		if (got !== exp) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, got);
			mismatches++;
		end
	endtask

	task automatic check_result(nrsp_pkg::out_item_t got);
		nrsp_pkg::out_item_t exp;
		if (tagged_bytes_q.size() == 0) begin
			$display("%0t: result with nothing expected, expected none, actual %h", $time, got);
			mismatches++;
			return;
		end
		exp = tagged_bytes_q.pop_front();
		check_field("section", exp.section, got.section);
		check_field("content_byte", exp.content_byte, got.content_byte);
		check_field("record_done", exp.record_done, got.record_done);
		check_field("record_index", exp.record_index, got.record_index);
		check_field("record_tnf", exp.record_tnf, got.record_tnf);
		check_field("type_length", exp.type_length, got.type_length);
		check_field("id_length", exp.id_length, got.id_length);
		check_field("payload_length", exp.payload_length, got.payload_length);
		check_field("message_end", exp.message_end, got.message_end);
		check_field("status", exp.status, got.status);
	endtask

	// result side: random stalls per transfer, plus one long hold-off on request
	initial begin
		int unsigned gap;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = snk_gaps ? $urandom_range(0, 15) : 0;
			if (gap != 0) begin
				result_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			check_result(result_ch.payload);
			@(negedge clk);
		end
	end

	task automatic test_record_layouts();
		// short record with type, id and payload, then an empty one that ends the message
		add_record(flag_byte(1'b0, 1'b1, 1'b1, 3'd1), 8'd1, 8'd1, 32'd2, 2);
		add_record(flag_byte(1'b1, 1'b1, 1'b0, 3'd6), 8'd0, 8'd0, 32'd0, 0);
		msg_bytes.push_back(8'hFF);
		msg_bytes.push_back(8'h00);
		send_message();
		// long length form at full scale, buffer cut inside the payload
		add_record(flag_byte(1'b0, 1'b0, 1'b0, 3'd7), 8'd0, 8'd0, 32'hFFFF_FFFF, 2);
		send_message();
		// buffer of a lone flag byte
		msg_bytes.push_back(8'h00);
		send_message();
		// id flag with empty id; the last byte completes the record
		add_record(flag_byte(1'b0, 1'b1, 1'b1, 3'd0), 8'd0, 8'd0, 32'd1, 1);
		send_message();
	endtask

	task automatic test_record_limit();
		for (int unsigned i = 0; i <= nrsp_pkg::MAX_RECORDS; i++)
			add_record(flag_byte(1'b0, 1'b1, 1'b0, 3'(i)), 8'd0, 8'd0, 32'd0, 0);
		msg_bytes.push_back(8'h5A);
		send_message();
	endtask

	task automatic test_backpressure();
		src_gaps = 1'b0;
		snk_gaps = 1'b0;
		hold_req = 1'b1;
		add_record(flag_byte(1'b1, 1'b1, 1'b0, 3'd2), 8'd4, 8'd0, 32'd30, 30);
		send_message();
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
	endtask

	task automatic build_random_message();
		int unsigned nrec;
		logic        me, sr, il;
		logic [31:0] plen;
		int unsigned cap;
		int unsigned sel;
		bit          cut;
		cut  = 1'b0;
		nrec = ($urandom_range(0, 7) == 0) ?
			$urandom_range(nrsp_pkg::MAX_RECORDS, nrsp_pkg::MAX_RECORDS + 2) :
			$urandom_range(1, 4);
		for (int unsigned k = 0; k < nrec && !cut; k++) begin
			me  = (k == nrec - 1) ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 15) == 0);
			sr  = $urandom_range(0, 3) != 0;
			il  = 1'($urandom);
			cap = 1000;
			if (sr) begin
				plen = 32'(pick_len());
			end else begin
				sel = $urandom_range(0, 7);
				if (sel < 6) begin
					plen = $urandom_range(0, 9);
				end else if (sel == 6) begin
					plen = $urandom_range(256, 300);
				end else begin
					// too long to finish: send a few payload bytes and end the buffer there
					plen = $urandom;
					cap  = $urandom_range(0, 3);
					cut  = 1'b1;
				end
			end
			add_record(flag_byte(me, sr, il, 3'($urandom)), pick_len(), pick_len(), plen, cap);
		end
		if (!cut && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
		if (!cut && msg_bytes.size() > 1 && $urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
	endtask

	task automatic test_random_messages();
		while (sent_count < TOTAL_BYTES) begin
			src_gaps = $urandom_range(0, 3) != 0;
			snk_gaps = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 19) == 0)
				repeat ($urandom_range(1, 24)) msg_bytes.push_back(8'($urandom));
			else
				build_random_message();
			send_message();
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		byte_ch.valid   = 1'b0;
		byte_ch.payload = '0;
		reset_parser();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_record_layouts();
		test_record_limit();
		test_backpressure();
		test_random_messages();
		while (tagged_bytes_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> ndef_record_stream_parser.f
design/nrsp_pkg.sv
design/nrsp_if.sv
design/ndef_record_stream_parser.sv
sim/tb_ndef_record_stream_parser.sv
